@@ src/path_to_quadratic_segments_unit_defines.svh @@
// Assertion helpers shared by the outline-to-quadratic block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef PATH_TO_QUADRATIC_SEGMENTS_UNIT_DEFINES_SVH
`define PATH_TO_QUADRATIC_SEGMENTS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTQS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ptqs_pkg.sv @@
package ptqs_pkg;

  // Result coordinate width (fixed by the segment format)
  localparam int unsigned SEG_W = 36;
  // Operation code width
  localparam int unsigned OP_W = 3;

  typedef logic signed [SEG_W-1:0] seg_val_t;

  typedef enum logic [OP_W-1:0] {
    OP_MOVE  = 3'd0,
    OP_LINE  = 3'd1,
    OP_QUAD  = 3'd2,
    OP_CUBIC = 3'd3,
    OP_CLOSE = 3'd4
  } op_e;

  // Per-axis setup terms of one queued job.
  // Cubic: base = P0 scaled, t1/t2/t3 = first/second/third differences of the hull.
  // Single segment: base = P0 scaled, t1 = step to the end, t2 = control offset.
  typedef struct packed {
    seg_val_t base;
    seg_val_t t1;
    seg_val_t t2;
    seg_val_t t3;
  } axis_t;

  typedef struct packed {
    logic        cubic;
    axis_t [1:0] ax;   // 0 = x, 1 = y
  } job_t;

  // 3*v with a shift and an add
  function automatic seg_val_t times3(input seg_val_t v);
    return v + (v << 1);
  endfunction

endpackage

@@ src/ptqs_if.sv @@
// Command channel: one outline command per transaction
interface ptqs_cmd_if #(
  parameter int unsigned COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic [ptqs_pkg::OP_W-1:0]     operation;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] first_control_x;
  logic signed [COORD_WIDTH-1:0] first_control_y;
  logic signed [COORD_WIDTH-1:0] second_control_x;
  logic signed [COORD_WIDTH-1:0] second_control_y;

  modport source (
    output valid, operation, point_x, point_y, first_control_x, first_control_y,
           second_control_x, second_control_y,
    input  ready
  );
  modport sink (
    input  valid, operation, point_x, point_y, first_control_x, first_control_y,
           second_control_x, second_control_y,
    output ready
  );
endinterface

// Segment channel: one quadratic segment per transaction
interface ptqs_seg_if ();
  logic                   valid;
  logic                   ready;
  ptqs_pkg::seg_val_t     seg_start_x;
  ptqs_pkg::seg_val_t     seg_start_y;
  ptqs_pkg::seg_val_t     seg_control_x;
  ptqs_pkg::seg_val_t     seg_control_y;
  ptqs_pkg::seg_val_t     seg_end_x;
  ptqs_pkg::seg_val_t     seg_end_y;
  logic                   last_segment;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_control_x, seg_control_y,
           seg_end_x, seg_end_y, last_segment,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_control_x, seg_control_y,
           seg_end_x, seg_end_y, last_segment,
    output ready
  );
endinterface

@@ src/ptqs_seg_gen.sv @@
// Segment generator: forward-differencing stepper plus output register.
// Coordinates are tracked at a quarter of the result scale (F = E/4), so
// all updates are plain adds and results are exact modulo 2^SEG_W.
module ptqs_seg_gen #(
  parameter int unsigned SUBDIVISION_DEPTH = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  ptqs_pkg::job_t  job_i,
  output logic            job_ready_o,
  ptqs_seg_if.source      seg_o
);
  import ptqs_pkg::*;

  localparam int unsigned CNT_W = SUBDIVISION_DEPTH + 1;
  localparam logic [CNT_W-1:0] PIECES = CNT_W'(1) << SUBDIVISION_DEPTH;

  // Control registers
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Difference registers, one entry per axis
  seg_val_t f_q[2], f_d[2];
  seg_val_t df_q[2], df_d[2];
  seg_val_t d2f_q[2], d2f_d[2];
  seg_val_t d3f_q[2], d3f_d[2];
  seg_val_t c3_q[2], c3_d[2];

  // Output register payload
  seg_val_t start_q[2], start_d[2];
  seg_val_t ctl_q[2], ctl_d[2];
  seg_val_t end_q[2], end_d[2];
  logic     last_q, last_d;

  logic busy, last, emit, load;

  always_comb begin
    seg_val_t hull;
    seg_val_t tail;
    busy        = cnt_q != '0;
    last        = cnt_q == CNT_W'(1);
    emit        = busy && (!out_valid_q || seg_o.ready);
    job_ready_o = !busy || (emit && last);
    load        = job_valid_i && job_ready_o;
    out_valid_d = emit || (out_valid_q && !seg_o.ready);
    last_d      = last;

    // piece counter
    cnt_d = cnt_q;
    if (emit) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (load) begin
      cnt_d = job_i.cubic ? PIECES : CNT_W'(1);
    end

    hull = '0;
    tail = '0;
    for (int a = 0; a < 2; a++) begin
      // current piece: start 4F, end 4(F+dF), control 4F + 2dF - d2F + c3
      start_d[a] = f_q[a] << 2;
      end_d[a]   = (f_q[a] + df_q[a]) << 2;
      ctl_d[a]   = (f_q[a] << 2) + (df_q[a] << 1) - d2f_q[a] + c3_q[a];

      // step to the next piece
      f_d[a]   = f_q[a];
      df_d[a]  = df_q[a];
      d2f_d[a] = d2f_q[a];
      d3f_d[a] = d3f_q[a];
      c3_d[a]  = c3_q[a];
      if (emit) begin
        f_d[a]   = f_q[a] + df_q[a];
        df_d[a]  = df_q[a] + d2f_q[a];
        d2f_d[a] = d2f_q[a] + d3f_q[a];
      end

      // load a new job
      if (load) begin
        f_d[a] = job_i.ax[a].base;
        if (job_i.cubic) begin
          hull     = (job_i.ax[a].t1 << (2 * SUBDIVISION_DEPTH))
                   + (job_i.ax[a].t2 << SUBDIVISION_DEPTH);
          tail     = (job_i.ax[a].t2 << SUBDIVISION_DEPTH) + job_i.ax[a].t3;
          df_d[a]  = times3(hull) + job_i.ax[a].t3;
          d2f_d[a] = times3(tail) << 1;
          d3f_d[a] = times3(job_i.ax[a].t3) << 1;
          c3_d[a]  = times3(job_i.ax[a].t3);
        end else begin
          df_d[a]  = job_i.ax[a].t1;
          d2f_d[a] = '0;
          d3f_d[a] = '0;
          c3_d[a]  = job_i.ax[a].t2;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      f_q[a]   <= f_d[a];
      df_q[a]  <= df_d[a];
      d2f_q[a] <= d2f_d[a];
      d3f_q[a] <= d3f_d[a];
      c3_q[a]  <= c3_d[a];
    end
    if (emit) begin
      for (int a = 0; a < 2; a++) begin
        start_q[a] <= start_d[a];
        ctl_q[a]   <= ctl_d[a];
        end_q[a]   <= end_d[a];
      end
      last_q <= last_d;
    end
  end

  assign seg_o.valid         = out_valid_q;
  assign seg_o.seg_start_x   = start_q[0];
  assign seg_o.seg_start_y   = start_q[1];
  assign seg_o.seg_control_x = ctl_q[0];
  assign seg_o.seg_control_y = ctl_q[1];
  assign seg_o.seg_end_x     = end_q[0];
  assign seg_o.seg_end_y     = end_q[1];
  assign seg_o.last_segment  = last_q;

endmodule

@@ src/path_to_quadratic_segments_unit.sv @@
// Outline command to quadratic segment converter.
// cmd_i takes move, line, quadratic, cubic and close commands with signed
// coordinates carrying 6 fraction bits; seg_o returns quadratic segments
// with 3*SUBDIVISION_DEPTH+2 extra fraction bits, last_segment set on the
// final segment of each command. Both channels are valid/ready.
// The first segment of a command passes through the job register, the
// stepper and the output register. A line, quadratic or contour-closing
// line gives one segment; a cubic gives 2^SUBDIVISION_DEPTH segments (8
// by default), one per cycle from the forward-differencing stepper while
// seg_o does not stall. Commands that give no segment only update the pen
// state. Sustained rate: one segment per cycle while seg_o does not stall;
// one queued command waits in the job register while the stepper finishes
// the previous one. When seg_o stalls, the output register holds its
// segment, the stepper pauses and cmd_i drops ready once the job register
// is full.
// Reset clears the pen position, contour start and open flag and empties
// the job register and output register.
`include "path_to_quadratic_segments_unit_defines.svh"

module path_to_quadratic_segments_unit #(
  parameter int unsigned SUBDIVISION_DEPTH = 3,
  parameter int unsigned COORD_WIDTH       = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptqs_cmd_if.sink   cmd_i,
  ptqs_seg_if.source seg_o
);
  import ptqs_pkg::*;

  localparam int unsigned BASE_SHIFT = 3 * SUBDIVISION_DEPTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // Pen state
  coord_t cursor_x_q, cursor_x_d;
  coord_t cursor_y_q, cursor_y_d;
  coord_t start_x_q, start_x_d;
  coord_t start_y_q, start_y_d;
  logic   open_q, open_d;

  // Job register between command intake and the stepper
  logic job_valid_q, job_valid_d;
  job_t job_q, job_d;
  logic job_ready;

  logic accept, need_close, enq, to_start, quad, cubic;

  function automatic seg_val_t ext(input coord_t v);
    return SEG_W'(v);
  endfunction

  // Setup terms of one axis; p0 is the pen, p3 the end point
  function automatic axis_t make_axis(input logic is_cubic, input logic is_quad,
                                      input seg_val_t p0, input seg_val_t p1,
                                      input seg_val_t p2, input seg_val_t p3);
    axis_t r;
    r.base = p0 << BASE_SHIFT;
    if (is_cubic) begin
      r.t1 = p1 - p0;
      r.t2 = (p0 + p2) - (p1 << 1);
      r.t3 = (p3 - p0) + times3(p1 - p2);
    end else begin
      r.t1 = (p3 - p0) << BASE_SHIFT;
      r.t2 = is_quad ? (p1 << (BASE_SHIFT + 2)) - ((p0 + p3) << (BASE_SHIFT + 1)) : '0;
      r.t3 = '0;
    end
    return r;
  endfunction

  assign cmd_i.ready = !job_valid_q || job_ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign need_close  = open_q && ((cursor_x_q != start_x_q) || (cursor_y_q != start_y_q));

  // Command decode and pen state update
  always_comb begin
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    open_d      = open_q;
    job_valid_d = job_valid_q && !job_ready;
    job_d       = job_q;
    enq         = 1'b0;
    to_start    = 1'b0;
    quad        = 1'b0;
    cubic       = 1'b0;

    if (accept) begin
      case (op_e'(cmd_i.operation))
        OP_MOVE: begin
          enq        = need_close;
          to_start   = 1'b1;
          cursor_x_d = cmd_i.point_x;
          cursor_y_d = cmd_i.point_y;
          start_x_d  = cmd_i.point_x;
          start_y_d  = cmd_i.point_y;
          open_d     = 1'b1;
        end
        OP_LINE: begin
          enq        = 1'b1;
          cursor_x_d = cmd_i.point_x;
          cursor_y_d = cmd_i.point_y;
        end
        OP_QUAD: begin
          enq        = 1'b1;
          quad       = 1'b1;
          cursor_x_d = cmd_i.point_x;
          cursor_y_d = cmd_i.point_y;
        end
        OP_CUBIC: begin
          enq        = 1'b1;
          cubic      = 1'b1;
          cursor_x_d = cmd_i.point_x;
          cursor_y_d = cmd_i.point_y;
        end
        OP_CLOSE: begin
          if (open_q) begin
            enq        = need_close;
            to_start   = 1'b1;
            cursor_x_d = start_x_q;
            cursor_y_d = start_y_q;
            open_d     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (enq) begin
      job_valid_d = 1'b1;
      job_d.cubic = cubic;
      job_d.ax[0] = make_axis(cubic, quad, ext(cursor_x_q), ext(cmd_i.first_control_x),
                              ext(cmd_i.second_control_x),
                              ext(to_start ? start_x_q : cmd_i.point_x));
      job_d.ax[1] = make_axis(cubic, quad, ext(cursor_y_q), ext(cmd_i.first_control_y),
                              ext(cmd_i.second_control_y),
                              ext(to_start ? start_y_q : cmd_i.point_y));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      open_q      <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      open_q      <= open_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // Segment stepper and output register
  ptqs_seg_gen #(
    .SUBDIVISION_DEPTH(SUBDIVISION_DEPTH)
  ) u_seg_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid_q),
    .job_i       (job_q),
    .job_ready_o (job_ready),
    .seg_o       (seg_o)
  );

  // Assertions
  `PTQS_ASSERT_SAME(a_ready_when_empty, !job_valid_q, cmd_i.ready, "intake blocked with empty job register")
  `PTQS_ASSERT_NEXT(a_job_hold, job_valid_q && !job_ready, job_valid_q && $stable(job_q), "queued job lost or changed")
  `PTQS_ASSERT_NEXT(a_draw_queues, accept && (cmd_i.operation == OP_LINE || cmd_i.operation == OP_QUAD || cmd_i.operation == OP_CUBIC), job_valid_q, "drawing command produced no job")
  `PTQS_ASSERT_NEXT(a_move_opens, accept && (cmd_i.operation == OP_MOVE), open_q && (cursor_x_q == start_x_q) && (cursor_y_q == start_y_q), "move did not open a contour at the pen")

endmodule

@@ dv/path_to_quadratic_segments_unit_tb.sv @@
`timescale 1ns / 100ps

module path_to_quadratic_segments_unit_tb;
  import ptqs_pkg::*;

  localparam int unsigned DEPTH      = 3;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned FRAC_EXTRA = 3 * DEPTH + 2;
  localparam int unsigned N_ITEMS    = 460;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned TAIL       = 20;
  localparam int unsigned MAX_REPORT = 10;

  // Operation codes that the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic            drain;  // hold off until all segments are back
    logic [OP_W-1:0] op;
    coord_t          px;
    coord_t          py;
    coord_t          ax;
    coord_t          ay;
    coord_t          bx;
    coord_t          by;
  } cmd_t;

  typedef struct packed {
    seg_val_t sx;
    seg_val_t sy;
    seg_val_t cx;
    seg_val_t cy;
    seg_val_t ex;
    seg_val_t ey;
    logic     last;
  } seg_t;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  typedef struct {
    pt_t a;
    pt_t b;
    pt_t c;
    pt_t d;
  } hull_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Driver and receiver registers
  logic drv_valid = 1'b0;
  cmd_t drv_cmd   = '0;
  logic seg_rdy   = 1'b0;

  cmd_t pending_cmds[$];
  seg_t segments_due[$];

  int unsigned sent_n  = 0;
  int unsigned real_n  = 0;
  int unsigned seg_n   = 0;
  int unsigned err_n   = 0;
  int unsigned cycle_n = 0;
  logic        calm;

  // Predicted pen state
  coord_t pen_x         = '0;
  coord_t pen_y         = '0;
  coord_t start_x       = '0;
  coord_t start_y       = '0;
  logic   contour_open  = 1'b0;

  ptqs_cmd_if #(.COORD_WIDTH(COORD_W)) cmd_bus ();
  ptqs_seg_if seg_bus ();

  assign cmd_bus.valid            = drv_valid;
  assign cmd_bus.operation        = drv_cmd.op;
  assign cmd_bus.point_x          = drv_cmd.px;
  assign cmd_bus.point_y          = drv_cmd.py;
  assign cmd_bus.first_control_x  = drv_cmd.ax;
  assign cmd_bus.first_control_y  = drv_cmd.ay;
  assign cmd_bus.second_control_x = drv_cmd.bx;
  assign cmd_bus.second_control_y = drv_cmd.by;
  assign seg_bus.ready            = seg_rdy;

  // No idling on either side through a stretch of the run
  assign calm = (sent_n >= 200) && (sent_n < 300);

  path_to_quadratic_segments_unit #(
    .SUBDIVISION_DEPTH(DEPTH),
    .COORD_WIDTH      (COORD_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .seg_o (seg_bus)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
  end

  // Point with the extra fraction bits of the segment format
  function automatic pt_t scaled_pt(coord_t x, coord_t y);
    pt_t p;
    p.x = longint'(x) * (longint'(1) << FRAC_EXTRA);
    p.y = longint'(y) * (longint'(1) << FRAC_EXTRA);
    return p;
  endfunction

  function automatic pt_t mid_pt(pt_t a, pt_t b);
    pt_t m;
    m.x = (a.x + b.x) / 2;
    m.y = (a.y + b.y) / 2;
    return m;
  endfunction

  function automatic void push_segment(pt_t s, pt_t c, pt_t e);
    seg_t item;
    item.sx   = SEG_W'(s.x);
    item.sy   = SEG_W'(s.y);
    item.cx   = SEG_W'(c.x);
    item.cy   = SEG_W'(c.y);
    item.ex   = SEG_W'(e.x);
    item.ey   = SEG_W'(e.y);
    item.last = 1'b0;
    segments_due = {segments_due, item};
  endfunction

  function automatic void draw_line(coord_t x, coord_t y);
    pt_t s;
    pt_t e;
    s = scaled_pt(pen_x, pen_y);
    e = scaled_pt(x, y);
    push_segment(s, mid_pt(s, e), e);
    pen_x = x;
    pen_y = y;
  endfunction

  // Closing line only when the pen is away from the contour start
  function automatic void close_path();
    if (contour_open) begin
      if (pen_x != start_x || pen_y != start_y) begin
        draw_line(start_x, start_y);
      end
      contour_open = 1'b0;
    end
  endfunction

  function automatic void predict_segments(cmd_t c);
    int    n_prior;
    hull_t work[$];
    hull_t halves[$];
    hull_t h;
    hull_t lo;
    hull_t hi;
    pt_t   ab, bc, cd, abc, bcd, m, ctl;
    n_prior = segments_due.size();
    case (c.op)
      OP_MOVE: begin
        close_path();
        pen_x        = c.px;
        pen_y        = c.py;
        start_x      = c.px;
        start_y      = c.py;
        contour_open = 1'b1;
      end
      OP_LINE: draw_line(c.px, c.py);
      OP_QUAD: begin
        push_segment(scaled_pt(pen_x, pen_y), scaled_pt(c.ax, c.ay), scaled_pt(c.px, c.py));
        pen_x = c.px;
        pen_y = c.py;
      end
      OP_CUBIC: begin
        h.a = scaled_pt(pen_x, pen_y);
        h.b = scaled_pt(c.ax, c.ay);
        h.c = scaled_pt(c.bx, c.by);
        h.d = scaled_pt(c.px, c.py);
        work = {work, h};
        // de Casteljau halving, pieces kept in curve order
        for (int lv = 0; lv < DEPTH; lv++) begin
          halves = {};
          foreach (work[i]) begin
            h   = work[i];
            ab  = mid_pt(h.a, h.b);
            bc  = mid_pt(h.b, h.c);
            cd  = mid_pt(h.c, h.d);
            abc = mid_pt(ab, bc);
            bcd = mid_pt(bc, cd);
            m   = mid_pt(abc, bcd);
            lo  = '{h.a, ab, abc, m};
            hi  = '{m, bcd, cd, h.d};
            halves = {halves, lo, hi};
          end
          work = halves;
        end
        foreach (work[i]) begin
          h     = work[i];
          ctl.x = (3 * (h.b.x + h.c.x) - (h.a.x + h.d.x)) / 4;
          ctl.y = (3 * (h.b.y + h.c.y) - (h.a.y + h.d.y)) / 4;
          push_segment(h.a, ctl, h.d);
        end
        pen_x = c.px;
        pen_y = c.py;
      end
      OP_CLOSE: close_path();
      default: ;
    endcase
    if (segments_due.size() > n_prior) begin
      segments_due[segments_due.size() - 1].last = 1'b1;
    end
  endfunction

  // Coordinates biased toward extremes and small values
  function automatic coord_t any_coord();
    case ($urandom_range(9))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3, 4, 5: return COORD_W'($urandom_range(8191) - 4096);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic cmd_t mk_cmd(logic [OP_W-1:0] op, coord_t px, coord_t py,
                                  coord_t ax, coord_t ay, coord_t bx, coord_t by);
    cmd_t c;
    c.drain = 1'b0;
    c.op    = op;
    c.px    = px;
    c.py    = py;
    c.ax    = ax;
    c.ay    = ay;
    c.bx    = bx;
    c.by    = by;
    return c;
  endfunction

  task automatic add_cmd(input cmd_t c);
    pending_cmds = {pending_cmds, c};
    if (c.op <= OP_CLOSE) real_n++;
  endtask

  // Command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || cmd_bus.ready) begin
      if (drv_valid) sent_n <= sent_n + 1;
      if (pending_cmds.size() == 0 || (!calm && $urandom_range(99) < 20) ||
          (pending_cmds[0].drain && (drv_valid || segments_due.size() != 0))) begin
        drv_valid <= 1'b0;
      end else begin
        drv_cmd   <= pending_cmds.pop_front();
        drv_valid <= 1'b1;
      end
    end
  end

  // Segment receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seg_rdy <= 1'b0;
    end else begin
      seg_rdy <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Monitor: predict on command transactions, check segment transactions
  always @(posedge clk_i) begin
    seg_t got;
    seg_t want;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) predict_segments(drv_cmd);
      if (seg_bus.valid && seg_bus.ready) begin
        got.sx   = seg_bus.seg_start_x;
        got.sy   = seg_bus.seg_start_y;
        got.cx   = seg_bus.seg_control_x;
        got.cy   = seg_bus.seg_control_y;
        got.ex   = seg_bus.seg_end_x;
        got.ey   = seg_bus.seg_end_y;
        got.last = seg_bus.last_segment;
        if (segments_due.size() == 0) begin
          err_n++;
          if (err_n <= MAX_REPORT) begin
            $display("segment %0d unexpected: start (%0d,%0d) ctrl (%0d,%0d)",
                     seg_n, got.sx, got.sy, got.cx, got.cy);
            $display("  end (%0d,%0d) last %0b", got.ex, got.ey, got.last);
          end
        end else begin
          want = segments_due.pop_front();
          if (got !== want) begin
            err_n++;
            if (err_n <= MAX_REPORT) begin
              $display("segment %0d mismatch", seg_n);
              $display("  expected start (%0d,%0d) ctrl (%0d,%0d) end (%0d,%0d) last %0b",
                       want.sx, want.sy, want.cx, want.cy, want.ex, want.ey, want.last);
              $display("  actual   start (%0d,%0d) ctrl (%0d,%0d) end (%0d,%0d) last %0b",
                       got.sx, got.sy, got.cx, got.cy, got.ex, got.ey, got.last);
            end
          end
        end
        seg_n++;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    cmd_t            c;
    coord_t          sx, sy, tx, ty;
    logic [OP_W-1:0] op;
    int unsigned     n_draw;
    int unsigned     pick;
    logic            first_contour;

    // Directed: drawing and closing with no contour open
    add_cmd(mk_cmd(OP_CLOSE, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_LINE, C_MAX, C_MIN, any_coord(), any_coord(), any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_QUAD, C_MIN, C_MIN, C_MIN, C_MAX, any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_CUBIC, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN));
    add_cmd(mk_cmd(OP_CUBIC, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    // Open contour, close with a closing line, then a redundant close
    add_cmd(mk_cmd(OP_MOVE, C_MIN, C_MAX, any_coord(), any_coord(), any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_LINE, '0, '0, any_coord(), any_coord(), any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_CUBIC, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX));
    add_cmd(mk_cmd(OP_CLOSE, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_CLOSE, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    // Pen back at the start: close emits nothing
    add_cmd(mk_cmd(OP_MOVE, COORD_W'(100), COORD_W'(-200), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_LINE, COORD_W'(300), COORD_W'(400), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_LINE, COORD_W'(100), COORD_W'(-200), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_CLOSE, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    // Move on an open contour closes it first
    add_cmd(mk_cmd(OP_MOVE, COORD_W'(-1), COORD_W'(-1), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_QUAD, COORD_W'(1), COORD_W'(1), C_MAX, C_MAX, any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_MOVE, C_MAX, C_MAX, any_coord(), any_coord(), any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_MOVE, COORD_W'(5), COORD_W'(5), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    // Ignored codes
    add_cmd(mk_cmd(OP_UNUSED_FIRST, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_W'(OP_UNUSED_FIRST + 1), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_UNUSED_LAST, any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord()));
    add_cmd(mk_cmd(OP_CUBIC, '0, '0, '0, '0, '0, '0));
    add_cmd(mk_cmd(OP_LINE, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));

    // Random: mostly whole contours, some noise
    first_contour = 1'b1;
    while (real_n < N_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(3))
          0: op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
          1: op = OP_CLOSE;
          2: op = OP_LINE;
          default: op = OP_MOVE;
        endcase
        add_cmd(mk_cmd(op, any_coord(), any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord()));
      end else begin
        sx = any_coord();
        sy = any_coord();
        c = mk_cmd(OP_MOVE, sx, sy, any_coord(), any_coord(), any_coord(), any_coord());
        c.drain = first_contour || ($urandom_range(15) == 0);
        first_contour = 1'b0;
        add_cmd(c);
        n_draw = $urandom_range(1, 8);
        repeat (n_draw) begin
          pick = $urandom_range(9);
          if (pick < 3) op = OP_LINE;
          else if (pick < 6) op = OP_QUAD;
          else op = OP_CUBIC;
          if ($urandom_range(9) == 0) begin
            tx = sx;
            ty = sy;
          end else begin
            tx = any_coord();
            ty = any_coord();
          end
          add_cmd(mk_cmd(op, tx, ty, any_coord(), any_coord(), any_coord(), any_coord()));
        end
        if ($urandom_range(3) != 0) begin
          add_cmd(mk_cmd(OP_CLOSE, any_coord(), any_coord(), any_coord(), any_coord(),
                         any_coord(), any_coord()));
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all commands taken, all segments back, then a quiet tail
    while (pending_cmds.size() != 0 || drv_valid) @(posedge clk_i);
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    if (err_n == 0 && segments_due.size() == 0) begin
      $display("path_to_quadratic_segments_unit_tb: clean");
    end else begin
      $display("path_to_quadratic_segments_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_n < LIMIT) @(posedge clk_i);
    $display("path_to_quadratic_segments_unit_tb: errors");
    $finish;
  end

endmodule
